// File: src/brfbp_pkg.sv
// Shared types and operation codes for the byte ring FIFO with bit packer.
package brfbp_pkg;

    localparam int LANES  = 8;
    localparam int FREE_W = 14;

    typedef enum logic [2:0] {
        OP_PUSH8    = 3'd0,
        OP_PUSH16   = 3'd1,
        OP_PUSH64   = 3'd2,
        OP_PUSH_BIT = 3'd3,
        OP_FLUSH    = 3'd4,
        OP_POP      = 3'd5,
        OP_CLEAR    = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] data;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic [FREE_W-1:0] free_space;
        logic              data_available;
        logic              overrun;
        logic              underrun;
    } out_beat_t;

    typedef struct packed {
        logic [FREE_W-1:0] free_space;
        logic              data_available;
        logic              overrun;
        logic              underrun;
    } status_t;

endpackage

// File: src/byte_ring_fifo_with_bit_packer_unit.sv
// Top level: byte ring FIFO with bit packer over eight interleaved byte banks.
//
// A circular store of DEPTH bytes (DEPTH a multiple of 8) is split into eight
// banks by the low three address bits, so a push of 1, 2 or 8 bytes writes
// all of its bytes in the cycle it is accepted, one write port per bank. One
// beat is accepted per clock. Every beat gives exactly one result beat in the
// next cycle; the pop byte comes out of the registered read port of the
// bank that holds it, and the result waits in the output stage while
// m_ready is low, with the next beat accepted in the cycle it is taken.
// The store has no reset; a pop of a never-written location returns an
// unspecified byte. Status reports free space and data availability after
// the operation, plus overrun and underrun flags.
module byte_ring_fifo_with_bit_packer_unit #(
    parameter int DEPTH = 8192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  brfbp_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output brfbp_pkg::out_beat_t m_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int ROW_W = PTR_W - 3;
    localparam int BANK_DEPTH = DEPTH / 8;

    logic                 accept;
    logic [PTR_W-1:0]     wr_ptr, rd_ptr;
    logic [3:0]           push_cnt;
    logic                 use_cache;
    logic [7:0]           cache_byte;
    logic                 pop;
    brfbp_pkg::status_t   status;

    logic [7:0]           lane_byte [brfbp_pkg::LANES];
    logic [PTR_W-1:0]     lane_addr [brfbp_pkg::LANES];
    logic                 lane_en   [brfbp_pkg::LANES];
    logic [7:0]           bank_rdata [brfbp_pkg::LANES];

    logic                 p_valid_reg;
    logic                 p_pop_reg;
    logic [2:0]           p_bank_reg;
    brfbp_pkg::status_t   p_stat_reg;

    assign s_ready = !p_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    brfbp_ptr #(.DEPTH(DEPTH)) u_ptr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_data.operation),
        .bit_in     (s_data.data[0]),
        .wr_ptr     (wr_ptr),
        .rd_ptr     (rd_ptr),
        .push_cnt   (push_cnt),
        .use_cache  (use_cache),
        .cache_byte (cache_byte),
        .pop        (pop),
        .status     (status)
    );

    for (genvar i = 0; i < brfbp_pkg::LANES; i++) begin : g_lane
        if (i == 0) begin : g_first
            assign lane_byte[i] = use_cache ? cache_byte : s_data.data[7:0];
        end else begin : g_rest
            assign lane_byte[i] = s_data.data[8*i +: 8];
        end

        brfbp_lane #(.DEPTH(DEPTH), .LANE(i)) u_lane (
            .wr_ptr   (wr_ptr),
            .push_cnt (push_cnt),
            .addr     (lane_addr[i]),
            .en       (lane_en[i])
        );
    end

    // bank k takes the lane whose address lands on it
    for (genvar k = 0; k < brfbp_pkg::LANES; k++) begin : g_bank
        logic [2:0]       sel;
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic             re;

        assign sel   = 3'(k) - wr_ptr[2:0];
        assign we    = accept && lane_en[sel];
        assign waddr = lane_addr[sel][PTR_W-1:3];
        assign re    = accept && pop && (rd_ptr[2:0] == 3'(k));

        brfbp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (lane_byte[sel]),
            .re    (re),
            .raddr (rd_ptr[PTR_W-1:3]),
            .rdata (bank_rdata[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
        if (accept) begin
            p_pop_reg  <= pop;
            p_bank_reg <= rd_ptr[2:0];
            p_stat_reg <= status;
        end
    end

    assign m_valid = p_valid_reg;

    always_comb begin
        m_data.read_byte      = p_pop_reg ? bank_rdata[p_bank_reg] : 8'd0;
        m_data.free_space     = p_stat_reg.free_space;
        m_data.data_available = p_stat_reg.data_available;
        m_data.overrun        = p_stat_reg.overrun;
        m_data.underrun       = p_stat_reg.underrun;
    end

endmodule

// File: src/brfbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brfbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/brfbp_lane.sv
// One byte lane of a push: wrapped target address and lane enable.
module brfbp_lane #(
    parameter int DEPTH = 8192,
    parameter int LANE  = 0
) (
    input  logic [$clog2(DEPTH)-1:0] wr_ptr,
    input  logic [3:0]               push_cnt,
    output logic [$clog2(DEPTH)-1:0] addr,
    output logic                     en
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W:0] sum;

    always_comb begin
        sum = {1'b0, wr_ptr} + (PTR_W+1)'(LANE);
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
    end

    assign addr = sum[PTR_W-1:0];
    assign en   = (4'(LANE) < push_cnt);

endmodule

// File: src/brfbp_ptr.sv
// Pointer, full/empty flag and bit packer state; per-beat status computation.
module brfbp_ptr #(
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [2:0]               op,
    input  logic                     bit_in,
    output logic [$clog2(DEPTH)-1:0] wr_ptr,
    output logic [$clog2(DEPTH)-1:0] rd_ptr,
    output logic [3:0]               push_cnt,
    output logic                     use_cache,
    output logic [7:0]               cache_byte,
    output logic                     pop,
    output brfbp_pkg::status_t       status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             lww_reg, lww_next;
    logic [7:0]       cache_reg, cache_next;
    logic [2:0]       pos_reg, pos_next;

    logic [7:0]       packed_byte;
    logic             clr;
    logic [CNT_W-1:0] free_cur, free_after;
    logic [PTR_W:0]   wr_sum, rd_sum;

    function automatic logic [CNT_W-1:0] free_of(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r,
                                                 input logic             l);
        logic [CNT_W-1:0] f;
        if (r > w) begin
            f = CNT_W'(r) - CNT_W'(w);
        end else if (r < w) begin
            f = CNT_W'(DEPTH) - (CNT_W'(w) - CNT_W'(r));
        end else begin
            f = l ? '0 : CNT_W'(DEPTH);
        end
        return f;
    endfunction

    always_comb begin
        packed_byte = cache_reg | (8'(bit_in) << pos_reg);
        push_cnt    = 4'd0;
        use_cache   = 1'b0;
        cache_byte  = cache_reg;
        cache_next  = cache_reg;
        pos_next    = pos_reg;
        pop         = 1'b0;
        clr         = 1'b0;
        case (op)
            brfbp_pkg::OP_PUSH8:  push_cnt = 4'd1;
            brfbp_pkg::OP_PUSH16: push_cnt = 4'd2;
            brfbp_pkg::OP_PUSH64: push_cnt = 4'd8;
            brfbp_pkg::OP_PUSH_BIT: begin
                if (pos_reg == 3'd7) begin
                    push_cnt   = 4'd1;
                    use_cache  = 1'b1;
                    cache_byte = packed_byte;
                    cache_next = 8'd0;
                    pos_next   = 3'd0;
                end else begin
                    cache_next = packed_byte;
                    pos_next   = pos_reg + 3'd1;
                end
            end
            brfbp_pkg::OP_FLUSH: begin
                if (pos_reg != 3'd0) begin
                    push_cnt   = 4'd1;
                    use_cache  = 1'b1;
                    cache_next = 8'd0;
                    pos_next   = 3'd0;
                end
            end
            brfbp_pkg::OP_POP:   pop = 1'b1;
            brfbp_pkg::OP_CLEAR: clr = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        wr_sum = {1'b0, wr_ptr_reg} + (PTR_W+1)'(push_cnt);
        if (wr_sum >= (PTR_W+1)'(DEPTH)) begin
            wr_sum = wr_sum - (PTR_W+1)'(DEPTH);
        end
        rd_sum = {1'b0, rd_ptr_reg} + (PTR_W+1)'(1);
        if (rd_sum >= (PTR_W+1)'(DEPTH)) begin
            rd_sum = rd_sum - (PTR_W+1)'(DEPTH);
        end

        if (clr) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            lww_next    = 1'b0;
        end else begin
            wr_ptr_next = wr_sum[PTR_W-1:0];
            rd_ptr_next = pop ? rd_sum[PTR_W-1:0] : rd_ptr_reg;
            if (pop) begin
                lww_next = 1'b0;
            end else if (push_cnt != 4'd0) begin
                lww_next = 1'b1;
            end else begin
                lww_next = lww_reg;
            end
        end
    end

    assign free_cur   = free_of(wr_ptr_reg, rd_ptr_reg, lww_reg);
    assign free_after = free_of(wr_ptr_next, rd_ptr_next, lww_next);

    always_comb begin
        status.free_space     = brfbp_pkg::FREE_W'(free_after);
        status.data_available = lww_next || (wr_ptr_next != rd_ptr_next);
        status.overrun        = {{(CNT_W-4){1'b0}}, push_cnt} > free_cur;
        status.underrun       = pop && !(lww_reg || (wr_ptr_reg != rd_ptr_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lww_reg    <= 1'b0;
            cache_reg  <= 8'd0;
            pos_reg    <= 3'd0;
        end else if (accept) begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lww_reg    <= lww_next;
            cache_reg  <= cache_next;
            pos_reg    <= pos_next;
        end
    end

    assign wr_ptr = wr_ptr_reg;
    assign rd_ptr = rd_ptr_reg;

endmodule

// File: src/brfbp_checker.sv
// Port-level checks for the byte ring FIFO with bit packer, bound to the top.
module brfbp_checker #(
    parameter int DEPTH = 8192
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input brfbp_pkg::out_beat_t m_data
);

    localparam logic [brfbp_pkg::FREE_W-1:0] EMPTY_FREE = brfbp_pkg::FREE_W'(DEPTH);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // every accepted beat yields a result beat in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    a_empty_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.data_available |-> m_data.free_space == EMPTY_FREE)
        else $error("empty queue reports wrong free space");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.overrun && m_data.underrun))
        else $error("overrun and underrun in the same beat");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind byte_ring_fifo_with_bit_packer_unit brfbp_checker #(.DEPTH(DEPTH)) u_brfbp_checker (.*);

// File: verif/tb_top.sv
// Testbench for the byte ring FIFO with bit packer: directed and random beats vs. a local model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 8192;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int GAP_MAX = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    brfbp_pkg::in_beat_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    brfbp_pkg::out_beat_t m_data;

    always #6 aclk = ~aclk;

    byte_ring_fifo_with_bit_packer_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Model of the ring, pointers and bit packer
    logic [7:0]  ring_mem [RING];
    bit          ring_written [RING];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;
    bit          last_write = 1'b0;
    logic [7:0]  pack_cache = '0;
    int unsigned pack_pos = 0;

    brfbp_pkg::out_beat_t pending_results [$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        quiet_cycles = 0;

    function automatic int unsigned ring_free_bytes();
        if (rd_ptr > wr_ptr) return rd_ptr - wr_ptr;
        if (rd_ptr < wr_ptr) return RING - (wr_ptr - rd_ptr);
        return last_write ? 0 : RING;
    endfunction

    function automatic bit ring_not_empty();
        return last_write || (wr_ptr != rd_ptr);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic ring_push(input logic [63:0] value, input int count, output bit over);
        over = count > ring_free_bytes();
        for (int i = 0; i < count; i++) begin
            ring_mem[wr_ptr] = value[8*i +: 8];
            ring_written[wr_ptr] = 1'b1;
            wr_ptr = (wr_ptr + 1) % RING;
            last_write = 1'b1;
        end
    endtask

    task automatic apply_fifo_op(input brfbp_pkg::in_beat_t b,
                                 output brfbp_pkg::out_beat_t r);
        bit over;
        bit under;
        logic [7:0] popped;
        over = 1'b0;
        under = 1'b0;
        popped = '0;
        case (b.operation)
            brfbp_pkg::OP_PUSH8:  ring_push(b.data, 1, over);
            brfbp_pkg::OP_PUSH16: ring_push(b.data, 2, over);
            brfbp_pkg::OP_PUSH64: ring_push(b.data, 8, over);
            brfbp_pkg::OP_PUSH_BIT: begin
                pack_cache[pack_pos] = b.data[0];
                pack_pos++;
                if (pack_pos == 8) begin
                    ring_push({56'd0, pack_cache}, 1, over);
                    pack_cache = '0;
                    pack_pos = 0;
                end
            end
            brfbp_pkg::OP_FLUSH: begin
                if (pack_pos != 0) begin
                    ring_push({56'd0, pack_cache}, 1, over);
                    pack_cache = '0;
                    pack_pos = 0;
                end
            end
            brfbp_pkg::OP_POP: begin
                under = !ring_not_empty();
                popped = ring_mem[rd_ptr];
                rd_ptr = (rd_ptr + 1) % RING;
                last_write = 1'b0;
            end
            brfbp_pkg::OP_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                last_write = 1'b0;
            end
            default: ;
        endcase
        r.read_byte      = popped;
        r.free_space     = brfbp_pkg::FREE_W'(ring_free_bytes());
        r.data_available = ring_not_empty();
        r.overrun        = over;
        r.underrun       = under;
    endtask

    // Valid stays high across back-to-back beats; it only drops for an idle gap.
    task automatic send_beat(input logic [2:0] op, input logic [63:0] value);
        brfbp_pkg::in_beat_t  b;
        brfbp_pkg::out_beat_t r;
        int                   gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        // never pop a location that was not written since reset
        if (op == brfbp_pkg::OP_POP && !ring_written[rd_ptr]) op = brfbp_pkg::OP_PUSH8;
        b.operation = op;
        b.data      = value;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_fifo_op(b, r);
        pending_results.push_back(r);
    endtask

    task automatic test_push_widths();
        send_beat(brfbp_pkg::OP_PUSH8, 64'd0);
        send_beat(brfbp_pkg::OP_PUSH8, '1);
        send_beat(brfbp_pkg::OP_PUSH16, 64'd0);
        send_beat(brfbp_pkg::OP_PUSH64, '1);
        send_beat(brfbp_pkg::OP_PUSH64, 64'h0123_4567_89AB_CDEF);
    endtask

    task automatic test_pop_and_status();
        send_beat(brfbp_pkg::OP_POP, rand64());
        send_beat(brfbp_pkg::OP_POP, rand64());
        send_beat(OP_UNUSED, rand64());
    endtask

    task automatic test_bit_packing();
        logic [7:0] pattern;
        pattern = 8'b1100_1101;
        // upper data bits are noise; only bit 0 is packed
        for (int i = 0; i < 8; i++)
            send_beat(brfbp_pkg::OP_PUSH_BIT, {63'(rand64()), pattern[i]});
        send_beat(brfbp_pkg::OP_FLUSH, rand64());
    endtask

    task automatic test_clear_keeps_bits();
        repeat (3) send_beat(brfbp_pkg::OP_PUSH_BIT, 64'd1);
        send_beat(brfbp_pkg::OP_CLEAR, rand64());
        send_beat(brfbp_pkg::OP_FLUSH, rand64());
        send_beat(brfbp_pkg::OP_POP, rand64());
        // queue is empty here: underrun
        send_beat(brfbp_pkg::OP_POP, rand64());
    endtask

    task automatic test_fill_and_overrun();
        int n;
        int pick;
        n = 0;
        send_beat(brfbp_pkg::OP_CLEAR, rand64());
        while (ring_free_bytes() >= 8) begin
            if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 88)      send_beat(brfbp_pkg::OP_PUSH64, rand64());
            else if (pick < 92) send_beat(brfbp_pkg::OP_PUSH16, rand64());
            else if (pick < 95) send_beat(brfbp_pkg::OP_PUSH_BIT, rand64());
            else                send_beat(brfbp_pkg::OP_POP, rand64());
            n++;
        end
        while (ring_free_bytes() != 0) send_beat(brfbp_pkg::OP_PUSH8, rand64());
        // ring is full; every byte push from here on overruns, the flush too; a single bit does not
        send_beat(brfbp_pkg::OP_PUSH8, rand64());
        send_beat(brfbp_pkg::OP_PUSH16, rand64());
        send_beat(brfbp_pkg::OP_PUSH64, rand64());
        if (pack_pos == 0) send_beat(brfbp_pkg::OP_PUSH_BIT, rand64());
        send_beat(brfbp_pkg::OP_FLUSH, rand64());
        repeat (4) send_beat(brfbp_pkg::OP_POP, rand64());
        send_beat(brfbp_pkg::OP_CLEAR, rand64());
    endtask

    task automatic test_random_mix();
        int pick;
        for (int n = 0; n < 300; n++) begin
            if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 20)      send_beat(brfbp_pkg::OP_PUSH8, rand64());
            else if (pick < 30) send_beat(brfbp_pkg::OP_PUSH16, rand64());
            else if (pick < 40) send_beat(brfbp_pkg::OP_PUSH64, rand64());
            else if (pick < 65) send_beat(brfbp_pkg::OP_PUSH_BIT, rand64());
            else if (pick < 73) send_beat(brfbp_pkg::OP_FLUSH, rand64());
            else if (pick < 95) send_beat(brfbp_pkg::OP_POP, rand64());
            else if (pick < 98) send_beat(brfbp_pkg::OP_CLEAR, rand64());
            else                send_beat(OP_UNUSED, rand64());
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_push_widths();
        test_pop_and_status();
        test_bit_packing();
        test_clear_keeps_bits();
        test_fill_and_overrun();
        test_random_mix();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    // Result side: random stall before taking each beat
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        brfbp_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $realtime, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                report_field("read_byte", 64'(want.read_byte), 64'(m_data.read_byte));
                report_field("free_space", 64'(want.free_space), 64'(m_data.free_space));
                report_field("data_available", 64'(want.data_available),
                             64'(m_data.data_available));
                report_field("overrun", 64'(want.overrun), 64'(m_data.overrun));
                report_field("underrun", 64'(want.underrun), 64'(m_data.underrun));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
